### hw/rtl/prw_pkg.sv
// shared constants and codes for the psn retransmit window
package prw_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int SEQ_BITS_DEF     = 24;

  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int SEG_W = 8;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [SEG_W-1:0] seg_t;

  localparam op_t OP_SEND  = 2'd0;
  localparam op_t OP_ACK   = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_OUTSIDE = 2'd2;

endpackage

### hw/rtl/psn_retransmit_window.sv
// psn retransmit window: ring of outstanding psns with cumulative ack retirement
//
// One operation is taken at a time: a transfer on the input channel starts it and
// the result waits on the output channel until taken, with in_ready low meanwhile.
// A send, clear or unused code passes the execute and head states before out_valid;
// a cumulative ack inside the window passes execute, one pop step per entry retired
// and a final pop check, since the single read port of the entry memory and one shared
// modular subtract-and-compare unit visit one head entry per cycle. Entry storage is not
// cleared at reset; only state, head, occupancy and the sequence registers are.
module psn_retransmit_window #(
  parameter int WINDOW_DEPTH = prw_pkg::WINDOW_DEPTH_DEF,
  parameter int SEQ_BITS     = prw_pkg::SEQ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  prw_pkg::op_t                      operation,
  input  logic [SEQ_BITS-1:0]               psn,
  input  prw_pkg::seg_t                     seg_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output prw_pkg::status_t                  status,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0] retired_count,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0] outstanding_count,
  output logic [SEQ_BITS-1:0]               next_send_psn,
  output logic [SEQ_BITS-1:0]               last_acked_psn,
  output prw_pkg::seg_t                     head_segment_type
);
  import prw_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);
  localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(WINDOW_DEPTH);
  localparam logic [32:0]   DEPTH_33  = 33'(WINDOW_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state, state_next;
  op_t                 cur_op;
  logic [SEQ_BITS-1:0] cur_psn;
  seg_t                cur_kind;

  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       occ, occ_next;
  logic [SEQ_BITS-1:0] expected, expected_next;
  logic [SEQ_BITS-1:0] retired_seq, retired_seq_next;
  logic [SEQ_BITS-1:0] span, span_next;
  logic [CW-1:0]       retired, retired_next;
  status_t             res_status, res_status_next;

  // entry memory, one write and one registered read port
  logic [SEQ_BITS-1:0] mem_seq  [WINDOW_DEPTH];
  seg_t                mem_kind [WINDOW_DEPTH];
  logic [SEQ_BITS-1:0] rd_seq;
  seg_t                rd_kind;
  logic                wr_en;
  logic [AW-1:0]       tail;
  logic [CW:0]         tail_sum;

  // shared modular distance unit
  logic [SEQ_BITS-1:0] fwd;

  assign fwd      = cur_psn - rd_seq;
  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(occ);

  always_comb begin
    if (tail_sum >= DEPTH_W) begin
      tail = AW'(tail_sum - DEPTH_W);
    end else begin
      tail = AW'(tail_sum);
    end
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    occ_next         = occ;
    expected_next    = expected;
    retired_seq_next = retired_seq;
    span_next        = span;
    retired_next     = retired;
    res_status_next  = res_status;
    wr_en            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next      = S_EXEC;
          retired_next    = '0;
          res_status_next = ST_OK;
        end
      end
      S_EXEC: begin
        state_next = S_HEAD;
        unique case (cur_op)
          OP_SEND: begin
            if (occ == FULL_CNT) begin
              res_status_next = ST_FULL;
            end else begin
              wr_en         = 1'b1;
              occ_next      = occ + CW'(1);
              expected_next = cur_psn + SEQ_BITS'(1);
            end
          end
          OP_ACK: begin
            if (occ != '0) begin
              if (33'(fwd) >= DEPTH_33) begin
                res_status_next = ST_OUTSIDE;
              end else begin
                span_next  = fwd;
                state_next = S_POP;
              end
            end
          end
          OP_CLEAR: begin
            head_next        = '0;
            occ_next         = '0;
            expected_next    = '0;
            retired_seq_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        // rd_seq always holds the entry at the current head here
        if ((occ != '0) && (fwd <= span)) begin
          head_next        = (head == LAST_SLOT) ? '0 : head + AW'(1);
          occ_next         = occ - CW'(1);
          retired_seq_next = rd_seq;
          retired_next     = retired + CW'(1);
        end else begin
          state_next = S_OUT;
        end
      end
      S_HEAD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      occ         <= '0;
      expected    <= '0;
      retired_seq <= '0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      occ         <= occ_next;
      expected    <= expected_next;
      retired_seq <= retired_seq_next;
    end
  end

  always_ff @(posedge clk) begin
    span       <= span_next;
    retired    <= retired_next;
    res_status <= res_status_next;
    if (state == S_IDLE && in_valid) begin
      cur_op   <= operation;
      cur_psn  <= psn;
      cur_kind <= seg_tag;
    end
  end

  // read address follows head_next, so the registered read holds the entry at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_seq[tail]  <= cur_psn;
      mem_kind[tail] <= cur_kind;
    end
    rd_seq  <= mem_seq[head_next];
    rd_kind <= mem_kind[head_next];
  end

  assign in_ready          = (state == S_IDLE);
  assign out_valid         = (state == S_OUT);
  assign status            = res_status;
  assign retired_count     = retired;
  assign outstanding_count = occ;
  assign next_send_psn     = expected;
  assign last_acked_psn    = retired_seq;
  assign head_segment_type = (occ != '0) ? rd_kind : '0;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_CNT)
    else $error("occupancy beyond window depth");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_reject_no_retire: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> retired_count == '0)
    else $error("rejected operation retired entries");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) && (state_next == S_POP) |=> occ == $past(occ) - CW'(1))
    else $error("pop step did not retire one entry");
`endif

endmodule

### dv/tb.sv
// testbench for the psn retransmit window: every result checked against a predicted window
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prw_pkg::*;

  localparam int DEPTH       = WINDOW_DEPTH_DEF;
  localparam int SEQ_W       = SEQ_BITS_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 80;
  localparam int PRINT_CAP   = 40;

  localparam op_t OP_UNUSED = 2'd3;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    status_t status;
    cnt_t    retired;
    cnt_t    outstanding;
    seq_t    next_send;
    seq_t    last_acked;
    seg_t    head_seg;
  } window_view_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  op_t     operation = OP_SEND;
  seq_t    psn = '0;
  seg_t    seg_tag = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  status_t status;
  cnt_t    retired_count;
  cnt_t    outstanding_count;
  seq_t    next_send_psn;
  seq_t    last_acked_psn;
  seg_t    head_segment_type;

  psn_retransmit_window dut (.*);

  always #2 clk = ~clk;

  // predicted window state
  seq_t        win_seq [DEPTH];
  seg_t        win_kind [DEPTH];
  int unsigned win_head = 0;
  int unsigned win_fill = 0;
  seq_t        win_next = '0;
  seq_t        win_acked = '0;

  window_view_t window_snapshots [$];

  bit steady_flow = 1'b0;
  int mismatches = 0;
  int results_checked = 0;
  int quiet_cycles = 0;
  int sends_done = 0, full_refusals = 0, acks_done = 0, acks_outside = 0;
  int clears_done = 0, unused_done = 0, most_retired = 0;

  function automatic window_view_t advance_window(op_t op, seq_t seq_no, seg_t kind);
    window_view_t v;
    seq_t         span;
    int unsigned  slot;
    v = '0;
    v.status = ST_OK;
    case (op)
      OP_SEND: begin
        if (win_fill == DEPTH) begin
          v.status = ST_FULL;
        end else begin
          slot = (win_head + win_fill) % DEPTH;
          win_seq[slot] = seq_no;
          win_kind[slot] = kind;
          win_fill++;
          win_next = seq_no + 1'b1;
        end
      end
      OP_ACK: begin
        if (win_fill != 0) begin
          span = seq_no - win_seq[win_head];
          if (span >= DEPTH) begin
            v.status = ST_OUTSIDE;
          end else begin
            // retire from the head while the entry sits no further back than the oldest
            while (win_fill != 0 && seq_t'(seq_no - win_seq[win_head]) <= span) begin
              win_acked = win_seq[win_head];
              win_head = (win_head + 1) % DEPTH;
              win_fill--;
              v.retired = v.retired + 1'b1;
            end
          end
        end
      end
      OP_CLEAR: begin
        win_head = 0;
        win_fill = 0;
        win_next = '0;
        win_acked = '0;
      end
      default: begin
      end
    endcase
    v.outstanding = cnt_t'(win_fill);
    v.next_send = win_next;
    v.last_acked = win_acked;
    v.head_seg = (win_fill != 0) ? win_kind[win_head] : '0;
    return v;
  endfunction

  function automatic int unsigned draw_gap();
    if (steady_flow || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // one operation transfer; valid stays up afterwards unless the next call or a drain lowers it
  task automatic send_op(op_t op, seq_t seq_no, seg_t kind);
    int unsigned  gap;
    window_view_t v;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    psn <= seq_no;
    seg_tag <= kind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = advance_window(op, seq_no, kind);
    window_snapshots.push_back(v);
    case (op)
      OP_SEND: begin
        sends_done++;
        if (v.status == ST_FULL) full_refusals++;
      end
      OP_ACK: begin
        acks_done++;
        if (v.status == ST_OUTSIDE) acks_outside++;
        if (int'(v.retired) > most_retired) most_retired = v.retired;
      end
      OP_CLEAR: clears_done++;
      default: unused_done++;
    endcase
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (window_snapshots.size() != 0) @(posedge clk);
  endtask

  // mostly in-order sends and acks inside the window, with some noise
  task automatic run_traffic(int n);
    int unsigned pick;
    seq_t        oldest;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      oldest = (win_fill != 0) ? win_seq[win_head] : win_acked;
      if (pick < 45) begin
        send_op(OP_SEND, ($urandom_range(0, 9) == 0) ?
                win_next + seq_t'($urandom_range(1, 3)) : win_next, seg_t'($urandom));
      end else if (pick < 70) begin
        send_op(OP_ACK, oldest + seq_t'($urandom_range(0, (win_fill > 0) ? win_fill - 1 : 0)),
                seg_t'($urandom));
      end else if (pick < 80) begin
        send_op(OP_ACK, oldest + seq_t'($urandom_range(0, DEPTH - 1)), seg_t'($urandom));
      end else if (pick < 86) begin
        if ($urandom_range(0, 1) != 0)
          send_op(OP_ACK, oldest + seq_t'(DEPTH) + seq_t'($urandom_range(0, 1 << 23)),
                  seg_t'($urandom));
        else
          send_op(OP_ACK, oldest - seq_t'($urandom_range(1, 2000)), seg_t'($urandom));
      end else if (pick < 90) begin
        send_op(OP_SEND, seq_t'($urandom), seg_t'($urandom));
      end else if (pick < 93) begin
        send_op(OP_CLEAR, seq_t'($urandom), seg_t'($urandom));
      end else if (pick < 96) begin
        send_op(OP_UNUSED, seq_t'($urandom), seg_t'($urandom));
      end else begin
        send_op(OP_ACK, seq_t'($urandom), seg_t'($urandom));
      end
    end
  endtask

  task automatic test_directed_edges();
    send_op(OP_ACK, 24'd5, 8'h00);           // empty window: succeeds, nothing retired
    send_op(OP_UNUSED, 24'hFFFFFF, 8'hFF);
    send_op(OP_SEND, 24'h000000, 8'hFF);
    send_op(OP_SEND, 24'hFFFFFF, 8'h00);     // next psn wraps to zero
    send_op(OP_ACK, 24'hFFFFFF, 8'h00);      // far ahead of the oldest entry
    send_op(OP_ACK, 24'h000001, 8'hFF);      // only psn 0 goes
    send_op(OP_ACK, 24'hFFFFFF, 8'h00);
    send_op(OP_SEND, 24'hFFFFC0, 8'hA5);
    send_op(OP_SEND, 24'hFFFFC1, 8'h5A);
    send_op(OP_ACK, 24'h000000, 8'h00);      // exactly one window ahead: refused
    send_op(OP_ACK, 24'hFFFFFF, 8'hFF);      // one short of a window: both retired
    send_op(OP_SEND, 24'h123456, 8'h3C);
    send_op(OP_SEND, 24'hEDCBA9, 8'hC3);
    send_op(OP_ACK, 24'h123456, 8'h00);
    send_op(OP_CLEAR, 24'hFFFFFF, 8'hFF);
    send_op(OP_ACK, 24'h000000, 8'h00);
  endtask

  task automatic test_window_full(bit retire_all);
    seq_t base;
    base = seq_t'($urandom);
    send_op(OP_CLEAR, seq_t'($urandom), seg_t'($urandom));
    for (int i = 0; i < DEPTH; i++) send_op(OP_SEND, base + seq_t'(i), seg_t'($urandom));
    repeat ($urandom_range(1, 4)) send_op(OP_SEND, base + seq_t'(DEPTH), seg_t'($urandom));
    if (retire_all) begin
      // whole window in one ack, the longest walk of the head
      send_op(OP_ACK, base + seq_t'(DEPTH - 1), seg_t'($urandom));
    end else begin
      send_op(OP_ACK, base + seq_t'($urandom_range(0, 31)), seg_t'($urandom));
      send_op(OP_ACK, base + seq_t'($urandom_range(32, DEPTH - 1)), seg_t'($urandom));
    end
  endtask

  task automatic test_wrap_around();
    send_op(OP_CLEAR, seq_t'($urandom), seg_t'($urandom));
    send_op(OP_SEND, 24'hFFFFFF - seq_t'($urandom_range(0, 40)), seg_t'($urandom));
    run_traffic(100);
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    run_traffic(80);
    steady_flow = 1'b0;
  endtask

  task automatic test_mixed_traffic();
    repeat (3) begin
      run_traffic(105);
      wait_results_drained();
    end
  endtask

  // result side: stall a random while, then take the next transfer
  initial begin
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    window_view_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (window_snapshots.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = window_snapshots.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (retired_count !== want.retired)
          flag_mismatch($sformatf("retired_count %0d, expected %0d",
                                  retired_count, want.retired));
        if (outstanding_count !== want.outstanding)
          flag_mismatch($sformatf("outstanding_count %0d, expected %0d",
                                  outstanding_count, want.outstanding));
        if (next_send_psn !== want.next_send)
          flag_mismatch($sformatf("next_send_psn %h, expected %h",
                                  next_send_psn, want.next_send));
        if (last_acked_psn !== want.last_acked)
          flag_mismatch($sformatf("last_acked_psn %h, expected %h",
                                  last_acked_psn, want.last_acked));
        if (head_segment_type !== want.head_seg)
          flag_mismatch($sformatf("head_segment_type %h, expected %h",
                                  head_segment_type, want.head_seg));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_window_full(1'b1);
    test_window_full(1'b0);
    test_wrap_around();
    test_back_to_back();
    test_mixed_traffic();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d sends (%0d refused full), %0d acks (%0d out of window, up to %0d retired)",
             sends_done, full_refusals, acks_done, acks_outside, most_retired);
    $display("plus %0d clears and %0d unused codes; %0d results checked, %0d still awaited",
             clears_done, unused_done, results_checked, window_snapshots.size());
    if (mismatches == 0 && window_snapshots.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/prw_pkg.sv
hw/rtl/psn_retransmit_window.sv
dv/tb.sv
